### rtl/cvm_pkg.sv
// ----------------------------------------------------------------------------
// cvm_pkg: shared types and constants of the camera view matrix block
// Holds field widths, CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none
package cvm_pkg;
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int NSTG = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int ANG_W = 16;
  localparam int POS_W = 32;
  localparam int M_W   = 16;
  localparam int T_W   = 32;
  localparam int XY_W  = 34;
  localparam int Z_W   = 32;
  localparam logic signed [ANG_W-1:0] FULL_TURN    = 16'sd23040;
  localparam logic signed [ANG_W-1:0] HALF_TURN    = 16'sd11520;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 16'sd5760;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [M_W-1:0] ONE_Q14 = 16'sd16384;

  function automatic logic signed [Z_W-1:0] atan_entry(input int i);
    logic signed [Z_W-1:0] t [ATAN_ENTRIES];
    t = '{32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
          32'sd15000234, 32'sd7507429, 32'sd3754631, 32'sd1877430,
          32'sd938729, 32'sd469366, 32'sd234683, 32'sd117342,
          32'sd58671, 32'sd29335, 32'sd14668, 32'sd7334, 32'sd3667,
          32'sd1833, 32'sd917, 32'sd458, 32'sd229, 32'sd115, 32'sd57, 32'sd29};
    return t[i];
  endfunction

  typedef struct packed {
    logic signed [ANG_W-1:0] pitch;
    logic signed [ANG_W-1:0] yaw;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } pose_t;

  typedef struct packed {
    logic signed [M_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [T_W-1:0] tx, ty, tz;
  } view_t;
endpackage
`default_nettype wire

### rtl/cvm_if.sv
// ----------------------------------------------------------------------------
// cvm_if: valid/ready channels of the camera view matrix block
// One interface for poses and one for view matrices.
// ----------------------------------------------------------------------------
`default_nettype none
interface cvm_pose_if;
  logic valid;
  logic ready;
  logic signed [15:0] pitch;
  logic signed [15:0] yaw;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  modport source (output valid, pitch, yaw, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, pitch, yaw, pos_x, pos_y, pos_z, output ready);
endinterface

interface cvm_view_if;
  logic valid;
  logic ready;
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic signed [31:0] tx, ty, tz;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  tx, ty, tz, input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                tx, ty, tz, output ready);
endinterface
`default_nettype wire

### rtl/cvm_reduce.sv
// ----------------------------------------------------------------------------
// cvm_reduce: angle reduction ahead of the CORDIC
// Folds any angle into [-90, 90] degrees and flags a half-turn flip.
// ----------------------------------------------------------------------------
`default_nettype none
module cvm_reduce (
  input  wire logic signed [cvm_pkg::ANG_W-1:0] ang,
  output logic signed [cvm_pkg::ANG_W-1:0] red,
  output logic flip
);
  import cvm_pkg::*;
  logic signed [ANG_W+1:0] r;
  always_comb begin
    r = {{2{ang[ANG_W-1]}}, ang};
    if (r >= 18'sd23040) r = r - 18'sd23040;
    else if (r <= -18'sd23040) r = r + 18'sd23040;
    if (r < 0) r = r + 18'sd23040;
    if (r > 18'sd11520) r = r - 18'sd23040;
    flip = 1'b0;
    if (r > 18'sd5760) begin
      r = r - 18'sd11520;
      flip = 1'b1;
    end else if (r < -18'sd5760) begin
      r = r + 18'sd11520;
      flip = 1'b1;
    end
    red = r[ANG_W-1:0];
  end
endmodule
`default_nettype wire

### rtl/cvm_cordic.sv
// ----------------------------------------------------------------------------
// cvm_cordic: pipelined rotation-mode CORDIC
// One register stage per iteration, stalled by the shared enable.
// ----------------------------------------------------------------------------
`default_nettype none
module cvm_cordic (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic signed [cvm_pkg::ANG_W-1:0] ang,
  input  wire logic flip_in,
  output logic signed [cvm_pkg::M_W-1:0] cos_q14,
  output logic signed [cvm_pkg::M_W-1:0] sin_q14
);
  import cvm_pkg::*;
  logic signed [XY_W-1:0] x_r [NSTG+1];
  logic signed [XY_W-1:0] y_r [NSTG+1];
  logic signed [Z_W-1:0]  z_r [NSTG+1];
  logic                   f_r [NSTG+1];
  logic signed [XY_W-1:0] xf, yf, xc, yc;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CORDIC_GAIN;
      y_r[0] <= '0;
      z_r[0] <= Z_W'({{(Z_W-ANG_W){ang[ANG_W-1]}}, ang} <<< 16);
      f_r[0] <= flip_in;
    end
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_stg
    always_ff @(posedge clk) begin
      if (en) begin
        f_r[i+1] <= f_r[i];
        if (!z_r[i][Z_W-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_entry(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_entry(i);
        end
      end
    end
  end

  always_comb begin
    xf = f_r[NSTG] ? -x_r[NSTG] : x_r[NSTG];
    yf = f_r[NSTG] ? -y_r[NSTG] : y_r[NSTG];
    xc = (xf + 34'sd32768) >>> 16;
    yc = (yf + 34'sd32768) >>> 16;
    if (xc > 34'sd16384) xc = 34'sd16384;
    else if (xc < -34'sd16384) xc = -34'sd16384;
    if (yc > 34'sd16384) yc = 34'sd16384;
    else if (yc < -34'sd16384) yc = -34'sd16384;
    cos_q14 = xc[M_W-1:0];
    sin_q14 = yc[M_W-1:0];
  end
endmodule
`default_nettype wire

### rtl/cvm_matrix.sv
// ----------------------------------------------------------------------------
// cvm_matrix: rotation products and translation
// Three register stages: products, dot-product terms, sums and saturation.
// ----------------------------------------------------------------------------
`default_nettype none
module cvm_matrix (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic signed [cvm_pkg::M_W-1:0] cp, sp, cy, sy,
  input  wire logic signed [cvm_pkg::POS_W-1:0] px, py, pz,
  output cvm_pkg::view_t view
);
  import cvm_pkg::*;
  typedef logic signed [M_W-1:0] q14_t;
  typedef logic signed [47:0] term_t;
  q14_t m_r [9];
  logic signed [POS_W-1:0] p_r [3];
  term_t tm_r [9];
  q14_t m2_r [9];
  logic signed [T_W-1:0] t_r [3];
  q14_t m3_r [9];

  function automatic q14_t mul14(input q14_t a, input q14_t b);
    logic signed [31:0] p;
    p = (32'(a) * 32'(b) + 32'sd8192) >>> 14;
    if (p > 32'sd16384) p = 32'sd16384;
    else if (p < -32'sd16384) p = -32'sd16384;
    return p[M_W-1:0];
  endfunction

  function automatic logic signed [T_W-1:0] sat(input logic signed [49:0] acc);
    logic signed [49:0] v;
    v = (-acc + 50'sd8192) >>> 14;
    if (v > 50'sd2147483647) v = 50'sd2147483647;
    else if (v < -50'sd2147483648) v = -50'sd2147483648;
    return v[T_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= cy; m_r[1] <= '0; m_r[2] <= sy;
      m_r[3] <= mul14(sp, sy); m_r[4] <= cp; m_r[5] <= -mul14(sp, cy);
      m_r[6] <= -mul14(cp, sy); m_r[7] <= sp; m_r[8] <= mul14(cp, cy);
      p_r[0] <= px; p_r[1] <= py; p_r[2] <= pz;
      for (int k = 0; k < 9; k++) begin
        tm_r[k] <= 48'(m_r[k]) * 48'(p_r[k%3]);
        m2_r[k] <= m_r[k];
        m3_r[k] <= m2_r[k];
      end
      for (int k = 0; k < 3; k++)
        t_r[k] <= sat(50'(tm_r[3*k]) + 50'(tm_r[3*k+1]) + 50'(tm_r[3*k+2]));
    end
  end

  always_comb begin
    view.m00 = m3_r[0]; view.m01 = m3_r[1]; view.m02 = m3_r[2];
    view.m10 = m3_r[3]; view.m11 = m3_r[4]; view.m12 = m3_r[5];
    view.m20 = m3_r[6]; view.m21 = m3_r[7]; view.m22 = m3_r[8];
    view.tx = t_r[0]; view.ty = t_r[1]; view.tz = t_r[2];
  end
endmodule
`default_nettype wire

### rtl/camera_view_matrix.sv
// ----------------------------------------------------------------------------
// camera_view_matrix: world-to-view matrix of a first-person camera
// A request on the pose channel carries pitch, yaw (1/64 degree) and a
// Q16.16 position. The view channel returns the Q2.14 rotation rows of
// Rx(pitch)*Ry(yaw) and the saturated translation -R*position.
// Between acceptance and the result becoming valid the pipeline has one
// input register, CORDIC_STAGES + 1 CORDIC stages and three matrix stages.
// One pose is accepted in every cycle while the output is not stalled;
// the unrolled CORDIC and the product stages set this rate.
// The whole pipeline advances together. When the receiver stalls with a
// valid result at the output, the pipeline freezes and in_ready falls, so
// nothing is lost or repeated. Empty slots are not filled while stalled.
// Reset clears all valid bits; the datapath holds no state worth keeping.
// ----------------------------------------------------------------------------
`default_nettype none
module camera_view_matrix (
  input wire logic clk,
  input wire logic rst_n,
  cvm_pose_if.sink in_if,
  cvm_view_if.source out_if
);
  import cvm_pkg::*;
  localparam int DEPTH = NSTG + 5;
  logic [DEPTH-1:0] vld_r, vld_nxt;
  logic en;
  logic signed [ANG_W-1:0] pr, yr, pa_r, ya_r;
  logic pf, yf, pf_r, yf_r;
  logic signed [POS_W-1:0] px_r [NSTG+2], py_r [NSTG+2], pz_r [NSTG+2];
  logic signed [M_W-1:0] cp, sp, cy, sy;
  view_t view;

  assign en = !vld_r[DEPTH-1] || out_if.ready;
  assign in_if.ready = en;

  cvm_reduce u_rp (.ang(in_if.pitch), .red(pr), .flip(pf));
  cvm_reduce u_ry (.ang(in_if.yaw), .red(yr), .flip(yf));

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= pr; pf_r <= pf; ya_r <= yr; yf_r <= yf;
      px_r[0] <= in_if.pos_x; py_r[0] <= in_if.pos_y; pz_r[0] <= in_if.pos_z;
      for (int k = 1; k < NSTG + 2; k++) begin
        px_r[k] <= px_r[k-1]; py_r[k] <= py_r[k-1]; pz_r[k] <= pz_r[k-1];
      end
    end
  end

  cvm_cordic u_cp (.clk(clk), .en(en), .ang(pa_r), .flip_in(pf_r),
                   .cos_q14(cp), .sin_q14(sp));
  cvm_cordic u_cy (.clk(clk), .en(en), .ang(ya_r), .flip_in(yf_r),
                   .cos_q14(cy), .sin_q14(sy));

  cvm_matrix u_mat (.clk(clk), .en(en), .cp(cp), .sp(sp), .cy(cy), .sy(sy),
                    .px(px_r[NSTG+1]), .py(py_r[NSTG+1]), .pz(pz_r[NSTG+1]),
                    .view(view));

  assign vld_nxt = en ? {vld_r[DEPTH-2:0], in_if.valid} : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= vld_nxt;
  end

  assign out_if.valid = vld_r[DEPTH-1];
  assign out_if.m00 = view.m00; assign out_if.m01 = view.m01;
  assign out_if.m02 = view.m02; assign out_if.m10 = view.m10;
  assign out_if.m11 = view.m11; assign out_if.m12 = view.m12;
  assign out_if.m20 = view.m20; assign out_if.m21 = view.m21;
  assign out_if.m22 = view.m22;
  assign out_if.tx = view.tx; assign out_if.ty = view.ty; assign out_if.tz = view.tz;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.tx))
    else $error("stalled result changed");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_if.valid |-> in_if.ready)
    else $error("input blocked with empty output");
  a_m01: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> out_if.m01 == 16'sd0)
    else $error("m01 not zero");
endmodule
`default_nettype wire

### tb/cvm_tb_if.sv
// ----------------------------------------------------------------------------
// cvm_tb_if: clock and reset bundle of the view matrix testbench
// Carries the testbench reset to the block under test; the block's own pose
// and view interfaces serve as the testbench channels.
// ----------------------------------------------------------------------------
`default_nettype none
interface cvm_tb_clk_if (input logic clk);
  logic rst_n;
endinterface
`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the camera view matrix block
// Poses are sent over the pose channel and every view matrix that comes back
// is compared field by field with a matrix computed in the testbench from a
// CORDIC sine and cosine, under several patterns of idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cvm_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  cvm_tb_clk_if sys_if (.clk(clk));
  assign sys_if.rst_n = rst_n;

  cvm_pose_if in_if ();
  cvm_view_if out_if ();

  camera_view_matrix dut (.clk(clk), .rst_n(sys_if.rst_n), .in_if(in_if), .out_if(out_if));

  view_t expected_views[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  localparam longint ATAN_TAB [24] = '{188743680, 111421900, 58872272, 29884485,
    15000234, 7507429, 3754631, 1877430, 938729, 469366, 234683, 117342, 58671,
    29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void sin_cos(input logic signed [15:0] ang,
                                  output longint c, output longint s);
    longint r, x, y, z, xs, ys;
    bit flip;
    r = longint'(ang) % 23040;
    flip = 1'b0;
    if (r < 0) r += 23040;
    if (r > 11520) r -= 23040;
    if (r > 5760) begin
      r -= 11520;
      flip = 1'b1;
    end else if (r < -5760) begin
      r += 11520;
      flip = 1'b1;
    end
    x = 652032874;
    y = 0;
    z = r * 65536;
    for (int i = 0; i < NSTG; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= ATAN_TAB[i];
      end else begin
        x += ys;
        y -= xs;
        z += ATAN_TAB[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clip((x + 32768) >>> 16, -16384, 16384);
    s = clip((y + 32768) >>> 16, -16384, 16384);
  endfunction

  function automatic longint rmul(longint a, longint b);
    return clip((a * b + 8192) >>> 14, -16384, 16384);
  endfunction

  function automatic longint translate(longint r0, longint r1, longint r2, pose_t p);
    longint acc;
    acc = r0 * longint'(p.pos_x) + r1 * longint'(p.pos_y) + r2 * longint'(p.pos_z);
    return clip((-acc + 8192) >>> 14, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic view_t view_of(pose_t p);
    longint cp, sp, cy, sy;
    longint m [9];
    view_t v;
    sin_cos(p.pitch, cp, sp);
    sin_cos(p.yaw, cy, sy);
    m = '{cy, 0, sy, rmul(sp, sy), cp, -rmul(sp, cy), -rmul(cp, sy), sp, rmul(cp, cy)};
    v.m00 = 16'(m[0]); v.m01 = 16'(m[1]); v.m02 = 16'(m[2]);
    v.m10 = 16'(m[3]); v.m11 = 16'(m[4]); v.m12 = 16'(m[5]);
    v.m20 = 16'(m[6]); v.m21 = 16'(m[7]); v.m22 = 16'(m[8]);
    v.tx = 32'(translate(m[0], m[1], m[2], p));
    v.ty = 32'(translate(m[3], m[4], m[5], p));
    v.tz = 32'(translate(m[6], m[7], m[8], p));
    return v;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send_pose(pose_t p);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.pitch <= p.pitch;
    in_if.yaw <= p.yaw;
    in_if.pos_x <= p.pos_x;
    in_if.pos_y <= p.pos_y;
    in_if.pos_z <= p.pos_z;
    do @(posedge clk); while (!in_if.ready);
    expected_views.push_back(view_of(p));
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] any_angle();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(46080)) - 16'sd23040;
      2: return 16'(16'($urandom_range(8)) * 16'sd2880 - 16'sd11520
                    + 16'($urandom_range(2)) - 1);
      default: return 16'($urandom_range(11520)) - 16'sd5760;
    endcase
  endfunction

  function automatic logic signed [31:0] any_pos();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(3)
                                   : 32'sh80000000 + $urandom_range(3);
      default: return 32'($urandom_range(2097152)) - 32'sd1048576;
    endcase
  endfunction

  task automatic send_random(int n);
    pose_t p;
    for (int i = 0; i < n; i++) begin
      p.pitch = any_angle();
      p.yaw = any_angle();
      p.pos_x = any_pos();
      p.pos_y = any_pos();
      p.pos_z = any_pos();
      send_pose(p);
    end
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_views.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    logic signed [15:0] angs [14] = '{16'sd0, 16'sd5760, -16'sd5760, 16'sd5761,
      -16'sd5761, 16'sd11520, -16'sd11520, 16'sd23040, -16'sd23040, 16'sh7fff,
      16'sh8000, 16'sd2880, 16'sd17280, -16'sd1};
    logic signed [31:0] poss [4] = '{32'sh7fffffff, 32'sh80000000, 32'sd0, 32'sd65536};
    pose_t p;
    for (int i = 0; i < 14; i++) begin
      p.pitch = angs[i];
      p.yaw = angs[13 - i];
      p.pos_x = poss[i % 4];
      p.pos_y = poss[(i + 1) % 4];
      p.pos_z = poss[(i + 3) % 4];
      send_pose(p);
    end
    p = '{pitch: 16'sd2880, yaw: 16'sd2880, pos_x: 32'sh80000000,
          pos_y: 32'sh80000000, pos_z: 32'sh80000000};
    send_pose(p);
    p.pos_x = 32'sh7fffffff; p.pos_y = 32'sh7fffffff; p.pos_z = 32'sh7fffffff;
    send_pose(p);
    wait_drained();
  endtask

  task automatic test_idle_phases();
    int idle [4] = '{0, 79, 0, 38};
    int stall [4] = '{0, 0, 79, 38};
    for (int k = 0; k < 4; k++) begin
      send_idle_pct = idle[k];
      recv_stall_pct = stall[k];
      send_random(420);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_cycles = 200;
    send_random(80);
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_if.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_if.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    view_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_views.size() == 0) begin
        report_mismatch("unexpected view", 0, 0);
      end else begin
        want = expected_views.pop_front();
        if (out_if.m00 !== want.m00) report_mismatch("m00", out_if.m00, want.m00);
        if (out_if.m01 !== want.m01) report_mismatch("m01", out_if.m01, want.m01);
        if (out_if.m02 !== want.m02) report_mismatch("m02", out_if.m02, want.m02);
        if (out_if.m10 !== want.m10) report_mismatch("m10", out_if.m10, want.m10);
        if (out_if.m11 !== want.m11) report_mismatch("m11", out_if.m11, want.m11);
        if (out_if.m12 !== want.m12) report_mismatch("m12", out_if.m12, want.m12);
        if (out_if.m20 !== want.m20) report_mismatch("m20", out_if.m20, want.m20);
        if (out_if.m21 !== want.m21) report_mismatch("m21", out_if.m21, want.m21);
        if (out_if.m22 !== want.m22) report_mismatch("m22", out_if.m22, want.m22);
        if (out_if.tx !== want.tx) report_mismatch("tx", out_if.tx, want.tx);
        if (out_if.ty !== want.ty) report_mismatch("ty", out_if.ty, want.ty);
        if (out_if.tz !== want.tz) report_mismatch("tz", out_if.tz, want.tz);
      end
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.pitch = '0;
    in_if.yaw = '0;
    in_if.pos_x = '0;
    in_if.pos_y = '0;
    in_if.pos_z = '0;
    out_if.ready = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_backpressure();
    test_idle_phases();
    repeat (NSTG + 40) @(negedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
rtl/cvm_pkg.sv
rtl/cvm_if.sv
rtl/cvm_reduce.sv
rtl/cvm_cordic.sv
rtl/cvm_matrix.sv
rtl/camera_view_matrix.sv
tb/cvm_tb_if.sv
tb/tb.sv
